[hw/rtl/bvc_pkg.sv]
package bvc_pkg;

    // Field and datapath widths
    localparam int CAL_W   = 14;              // calibration registers
    localparam int K_W     = 9;               // control setting plus one
    localparam int T_W     = 14;              // 15 * raw - 1024
    localparam int P_W     = K_W + T_W;       // first product
    localparam int SCALE_W = 11;              // 1000 or 1875
    localparam int NUM_W   = 33;              // full numerator, also quotient width
    localparam int DIV_W   = CAL_W + 2;       // divisor, discharge side is four times
    localparam int MV_W    = 13;
    localparam int UA_W    = 30;

    // Pipeline depth: three front stages, one cell per quotient bit, one output stage
    localparam int FRONT_STAGES = 3;
    localparam int LATENCY      = FRONT_STAGES + NUM_W + 1;

    localparam logic [CAL_W-1:0]   CAL_RESET     = 14'd14321;
    localparam logic [9:0]         CUR_MIN_RAW   = 10'd69;
    localparam logic [T_W-1:0]     CUR_OFFSET    = 14'd1024;
    localparam logic [SCALE_W-1:0] CHARGE_SCALE  = 11'd1000;
    localparam logic [SCALE_W-1:0] DISCH_SCALE   = 11'd1875;
    localparam logic [K_W-1:0]     SUPPLY_K      = 9'd256;
    localparam logic [MV_W-1:0]    MV_DEN        = 13'd1023;
    localparam logic [NUM_W-1:0]   UA_POS_LIMIT  = 33'd536870911;
    localparam logic [NUM_W-1:0]   UA_NEG_MAG    = 33'd536870912;
    localparam logic [UA_W-1:0]    UA_POS_SAT    = 30'h1FFF_FFFF;
    localparam logic [UA_W-1:0]    UA_NEG_SAT    = 30'h2000_0000;
    localparam logic [7:0]         ST3_ALLOWED   = 8'h08;

    // Configuration register indexes
    localparam logic CFG_CHARGE_CAL    = 1'b0;
    localparam logic CFG_DISCHARGE_CAL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_INVALID  = 2'd2,
        ST_BAD_MODE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_CHARGE     = 3'd1,
        MODE_DROPOUT    = 3'd2,
        MODE_SUPPLEMENT = 3'd3,
        MODE_DISCHARGE  = 3'd4,
        MODE_BAD_5      = 3'd5,
        MODE_BAD_6      = 3'd6,
        MODE_BAD_7      = 3'd7
    } t_mode;

    // Fields that ride alongside the division unchanged
    typedef struct packed {
        t_status          status;
        logic [MV_W-1:0]  mv;
        logic             neg;
    } t_side;

    // What one divider cell hands to the next
    typedef struct packed {
        logic              valid;
        t_side             side;
        logic [DIV_W-1:0]  rem;
        logic [NUM_W-1:0]  nq;    // dividend bits still to use, quotient bits shifted in
        logic [DIV_W-1:0]  div;
    } t_div;

endpackage

[hw/rtl/battery_voltage_current_converter_core.sv]
// Channel   Direction  Handshake                      Payload
// item in   input      start, accepted when !busy     i_current_control .. i_low_bits
// result    output     o_result_valid, one cycle      o_status, o_battery_millivolts,
//                                                     o_battery_microamps
// config    input      i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One item is accepted every cycle while busy is low; its result reaches the outputs through
// three front stages (decode, two multiplies), 33 divider cells, one per quotient bit, and
// the output register. The divider chain sets both the depth and the one-per-cycle rate.
// Synchronous reset clears all valid bits; busy falls and o_cfg_ready rises once the ready
// register is set after reset is released. Results cannot be stalled.
module battery_voltage_current_converter_core
    import bvc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [7:0]             i_current_control,
    input  logic [7:0]             i_status_one,
    input  logic [7:0]             i_status_three,
    input  logic [7:0]             i_voltage_high,
    input  logic [7:0]             i_current_high,
    input  logic [7:0]             i_low_bits,
    output logic                   o_result_valid,
    output logic [1:0]             o_status,
    output logic [MV_W-1:0]        o_battery_millivolts,
    output logic signed [UA_W-1:0] o_battery_microamps,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [CAL_W-1:0]       i_cfg_data
);

    logic             r_ready;
    logic [CAL_W-1:0] r_charge_cal;
    logic [CAL_W-1:0] r_discharge_cal;
    logic             accept;
    t_div             w_stage [NUM_W+1];
    t_div             last;
    logic [UA_W-1:0]  n_ua;

    assign accept      = start && r_ready;
    assign busy        = !r_ready;
    assign o_cfg_ready = r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready         <= 1'b0;
            r_charge_cal    <= CAL_RESET;
            r_discharge_cal <= CAL_RESET;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_valid && r_ready) begin
                case (i_cfg_index)
                    CFG_CHARGE_CAL:    r_charge_cal    <= i_cfg_data;
                    CFG_DISCHARGE_CAL: r_discharge_cal <= i_cfg_data;
                    default:           r_charge_cal    <= r_charge_cal;
                endcase
            end
        end
    end

    bvc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_current_control (i_current_control),
        .i_status_one      (i_status_one),
        .i_status_three    (i_status_three),
        .i_voltage_high    (i_voltage_high),
        .i_current_high    (i_current_high),
        .i_low_bits        (i_low_bits),
        .i_charge_cal      (r_charge_cal),
        .i_discharge_cal   (r_discharge_cal),
        .o_stage           (w_stage[0])
    );

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        bvc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // Saturate the quotient to the signed output range and apply the discharge sign.
    always_comb begin
        last = w_stage[NUM_W];
        if (last.side.neg) begin
            if (last.nq > UA_NEG_MAG) begin
                n_ua = UA_NEG_SAT;
            end else begin
                n_ua = ~last.nq[UA_W-1:0] + UA_W'(1);
            end
        end else begin
            if (last.nq > UA_POS_LIMIT) begin
                n_ua = UA_POS_SAT;
            end else begin
                n_ua = last.nq[UA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_status             <= last.side.status;
        o_battery_millivolts <= last.side.mv;
        o_battery_microamps  <= n_ua;
    end

endmodule

[hw/rtl/bvc_front.sv]
module bvc_front
    import bvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_current_control,
    input  logic [7:0]       i_status_one,
    input  logic [7:0]       i_status_three,
    input  logic [7:0]       i_voltage_high,
    input  logic [7:0]       i_current_high,
    input  logic [7:0]       i_low_bits,
    input  logic [CAL_W-1:0] i_charge_cal,
    input  logic [CAL_W-1:0] i_discharge_cal,
    output t_div             o_stage
);

    t_mode              mode;
    t_status            status;
    logic [9:0]         vraw;
    logic [9:0]         iraw;
    logic               is_charge;
    logic               is_disch;
    logic               zero;
    logic [DIV_W-1:0]   div_sel;
    logic [K_W-1:0]     k_sel;
    logic [T_W-1:0]     t15;
    logic [MV_W-1:0]    v5;
    logic [2:0]         q5;
    t_side              side;

    logic               r_s0_valid;
    t_side              r_s0_side;
    logic [K_W-1:0]     r_s0_k;
    logic [T_W-1:0]     r_s0_t;
    logic [DIV_W-1:0]   r_s0_div;
    logic               r_s0_charge;

    logic               r_s1_valid;
    t_side              r_s1_side;
    logic [P_W-1:0]     r_s1_p;
    logic [DIV_W-1:0]   r_s1_div;
    logic               r_s1_charge;

    t_div               r_s2;

    logic [P_W-1:0]         n_s1_p;
    logic [SCALE_W-1:0]     scale;
    logic [P_W+SCALE_W-1:0] n_num;

    always_comb begin
        mode = t_mode'(i_status_one[5:3]);
        vraw = {i_voltage_high, i_low_bits[1:0]};
        iraw = {i_current_high, i_low_bits[3:2]};

        if (i_status_one[7:6] != 2'b00) begin
            status = ST_BUSY;
        end else if ((i_status_three & ~ST3_ALLOWED) != 8'h00) begin
            status = ST_INVALID;
        end else if (mode == MODE_BAD_5 || mode == MODE_BAD_6 || mode == MODE_BAD_7) begin
            status = ST_BAD_MODE;
        end else begin
            status = ST_OK;
        end

        is_charge = (mode == MODE_CHARGE) || (mode == MODE_DROPOUT);
        is_disch  = (mode == MODE_SUPPLEMENT) || (mode == MODE_DISCHARGE);

        if (is_charge) begin
            div_sel = {2'b00, i_charge_cal};
        end else begin
            div_sel = {i_discharge_cal, 2'b00};
        end

        if (mode == MODE_SUPPLEMENT) begin
            k_sel = SUPPLY_K;
        end else begin
            k_sel = {1'b0, i_current_control} + K_W'(1);
        end

        t15 = {iraw, 4'b0000} - {4'b0000, iraw};

        zero = (status != ST_OK) || !(is_charge || is_disch) || (iraw < CUR_MIN_RAW) ||
               (div_sel == '0);

        // 5120 * v / 1023 equals 5 * v plus the whole number of times 1023 fits in 5 * v.
        v5 = {1'b0, vraw, 2'b00} + {3'b000, vraw};
        q5 = {2'b00, v5 >= MV_DEN} + {2'b00, v5 >= 13'(2 * MV_DEN)}
           + {2'b00, v5 >= 13'(3 * MV_DEN)} + {2'b00, v5 >= 13'(4 * MV_DEN)}
           + {2'b00, v5 >= 13'(5 * MV_DEN)};

        side.status = status;
        side.mv     = (status == ST_OK) ? (v5 + {10'd0, q5}) : '0;
        side.neg    = is_disch;

        n_s1_p = {{(P_W-K_W){1'b0}}, r_s0_k} * {{(P_W-T_W){1'b0}}, r_s0_t};
        scale  = r_s1_charge ? CHARGE_SCALE : DISCH_SCALE;
        n_num  = {{SCALE_W{1'b0}}, r_s1_p} * {{P_W{1'b0}}, scale};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else begin
            r_s0_valid <= i_accept;
            r_s1_valid <= r_s0_valid;
            r_s2.valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_side   <= side;
        r_s0_charge <= is_charge;
        // A zero current is a zero numerator over a divisor of one.
        if (zero) begin
            r_s0_k   <= '0;
            r_s0_t   <= '0;
            r_s0_div <= DIV_W'(1);
        end else begin
            r_s0_k   <= k_sel;
            r_s0_t   <= t15 - CUR_OFFSET;
            r_s0_div <= div_sel;
        end

        r_s1_side   <= r_s0_side;
        r_s1_p      <= n_s1_p;
        r_s1_div    <= r_s0_div;
        r_s1_charge <= r_s0_charge;

        r_s2.side <= r_s1_side;
        r_s2.rem  <= '0;
        r_s2.nq   <= n_num[NUM_W-1:0];
        r_s2.div  <= r_s1_div;
    end

    assign o_stage = r_s2;

endmodule

[hw/rtl/bvc_div_cell.sv]
module bvc_div_cell
    import bvc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_div i_stage,
    output t_div o_stage
);

    logic [DIV_W:0]   rem_ext;
    logic [DIV_W+1:0] diff;
    logic             qbit;
    t_div             r_stage;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    always_comb begin
        rem_ext = {i_stage.rem, i_stage.nq[NUM_W-1]};
        diff    = {1'b0, rem_ext} - {2'b00, i_stage.div};
        qbit    = ~diff[DIV_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage.side <= i_stage.side;
        r_stage.div  <= i_stage.div;
        r_stage.nq   <= {i_stage.nq[NUM_W-2:0], qbit};
        r_stage.rem  <= qbit ? diff[DIV_W-1:0] : rem_ext[DIV_W-1:0];
    end

    assign o_stage = r_stage;

endmodule

[hw/rtl/bvc_checker.sv]
module bvc_checker
    import bvc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_result_valid,
    input logic [1:0]             o_status,
    input logic [MV_W-1:0]        o_battery_millivolts,
    input logic signed [UA_W-1:0] o_battery_microamps
);

    // Every accepted item produces its result after the fixed pipeline depth.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_result_valid)
        else $error("result missing after accepted item");

    // Error results carry no measurements.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_OK) |->
            (o_battery_millivolts == '0 && o_battery_microamps == '0))
        else $error("error result with nonzero values");

    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_battery_millivolts <= 13'd5120))
        else $error("millivolts out of range");

    // The block is ready again in the cycle after reset is released.
    a_ready: assert property (@(posedge i_clk)
        ($past(i_rst_n) && i_rst_n) |-> !busy)
        else $error("busy after reset");

endmodule

bind battery_voltage_current_converter_core bvc_checker u_bvc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .start                (start),
    .busy                 (busy),
    .o_result_valid       (o_result_valid),
    .o_status             (o_status),
    .o_battery_millivolts (o_battery_millivolts),
    .o_battery_microamps  (o_battery_microamps)
);

[tb/tb_battery_voltage_current_converter_core.sv]
`timescale 1ns / 100ps

module tb_battery_voltage_current_converter_core;
    import bvc_pkg::*;

    typedef struct packed {
        logic [7:0] ctrl;
        logic [7:0] st1;
        logic [7:0] st3;
        logic [7:0] vhi;
        logic [7:0] ihi;
        logic [7:0] lsb;
    } meas_t;

    typedef struct packed {
        t_status          status;
        logic [MV_W-1:0]  mv;
        logic [UA_W-1:0]  ua;
    } reading_t;

    localparam int STALL_LIMIT    = 4000;
    localparam int ITEMS_PER_CAL  = 90;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [7:0]             i_current_control;
    logic [7:0]             i_status_one;
    logic [7:0]             i_status_three;
    logic [7:0]             i_voltage_high;
    logic [7:0]             i_current_high;
    logic [7:0]             i_low_bits;
    logic                   o_result_valid;
    logic [1:0]             o_status;
    logic [MV_W-1:0]        o_battery_millivolts;
    logic signed [UA_W-1:0] o_battery_microamps;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_index;
    logic [CAL_W-1:0]       i_cfg_data;

    meas_t            meas_pending[$];
    reading_t         reading_expected[$];
    logic [CAL_W-1:0] charge_cal_now;
    logic [CAL_W-1:0] disch_cal_now;
    int               mismatches  = 0;
    int               idle_cycles = 0;
    bit               took_item   = 1'b0;
    int               gap_left    = 0;
    int               burst_left  = 0;
    meas_t            drv_item;
    reading_t         want;
    reading_t         got;

    battery_voltage_current_converter_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_current_control    (i_current_control),
        .i_status_one         (i_status_one),
        .i_status_three       (i_status_three),
        .i_voltage_high       (i_voltage_high),
        .i_current_high       (i_current_high),
        .i_low_bits           (i_low_bits),
        .o_result_valid       (o_result_valid),
        .o_status             (o_status),
        .o_battery_millivolts (o_battery_millivolts),
        .o_battery_microamps  (o_battery_microamps),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Unsigned current magnitude before the sign is applied and before saturation.
    function automatic longint unsigned scaled_current(input longint unsigned k,
                                                       input logic [9:0] raw,
                                                       input longint unsigned scale,
                                                       input longint unsigned divisor);
        if (raw < CUR_MIN_RAW || divisor == 0)
            return 0;
        return scale * (k + 1) * (15 * longint'(raw) - CUR_OFFSET) / divisor;
    endfunction

    function automatic reading_t convert_reading(input meas_t m,
                                                 input logic [CAL_W-1:0] ccal,
                                                 input logic [CAL_W-1:0] dcal);
        reading_t          r;
        t_mode             mode;
        logic [9:0]        vraw;
        logic [9:0]        iraw;
        longint unsigned   k;
        longint unsigned   mag;
        longint            neg;
        r = '0;
        r.status = ST_OK;
        mode = t_mode'(m.st1[5:3]);
        vraw = {m.vhi, m.lsb[1:0]};
        iraw = {m.ihi, m.lsb[3:2]};
        if (m.st1[7:6] != 2'b00) begin
            r.status = ST_BUSY;
        end else if ((m.st3 & ~ST3_ALLOWED) != 8'h00) begin
            r.status = ST_INVALID;
        end else if (mode > MODE_DISCHARGE) begin
            r.status = ST_BAD_MODE;
        end else begin
            r.mv = MV_W'(longint'(vraw) * 5120 / MV_DEN);
            case (mode)
                MODE_CHARGE, MODE_DROPOUT: begin
                    mag = scaled_current(m.ctrl, iraw, CHARGE_SCALE, ccal);
                    r.ua = (mag > UA_POS_LIMIT) ? UA_POS_SAT : mag[UA_W-1:0];
                end
                MODE_SUPPLEMENT, MODE_DISCHARGE: begin
                    // Supplement mode runs at the full control setting.
                    k = (mode == MODE_DISCHARGE) ? longint'(m.ctrl) : 255;
                    mag = scaled_current(k, iraw, DISCH_SCALE, 4 * longint'(dcal));
                    neg = -longint'(mag);
                    r.ua = (mag > UA_NEG_MAG) ? UA_NEG_SAT : neg[UA_W-1:0];
                end
                default: begin
                    r.ua = '0;
                end
            endcase
        end
        return r;
    endfunction

    function automatic meas_t random_reading();
        meas_t      m;
        logic [9:0] near;
        m.ctrl = 8'($urandom_range(0, 255));
        m.st1  = 8'($urandom_range(0, 255));
        m.st3  = 8'($urandom_range(0, 255));
        m.vhi  = 8'($urandom_range(0, 255));
        m.ihi  = 8'($urandom_range(0, 255));
        m.lsb  = 8'($urandom_range(0, 255));
        // Most items are well-formed so that the current arithmetic is reached.
        if ($urandom_range(0, 99) < 85) begin
            m.st1 = {2'b00, 3'($urandom_range(0, 4)), m.st1[2:0]};
            m.st3 = m.st3 & ST3_ALLOWED;
        end
        if ($urandom_range(0, 9) == 0) begin
            near = 10'($urandom_range(60, 80));
            m.ihi = near[9:2];
            m.lsb[3:2] = near[1:0];
        end
        return m;
    endfunction

    function automatic meas_t mk(input logic [7:0] ctrl, input logic [7:0] st1,
                                 input logic [7:0] st3, input logic [7:0] vhi,
                                 input logic [7:0] ihi, input logic [7:0] lsb);
        return '{ctrl, st1, st3, vhi, ihi, lsb};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic write_cal(input logic idx, input logic [CAL_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_CHARGE_CAL)
            charge_cal_now = val;
        else
            disch_cal_now = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (meas_pending.size() != 0 || start || reading_expected.size() != 0);
    endtask

    // Driver: one item at a time from the pending queue, in bursts with gaps between.
    always @(negedge i_clk) begin
        if (took_item || !start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (meas_pending.size() > 0) begin
                drv_item = meas_pending.pop_front();
                i_current_control <= drv_item.ctrl;
                i_status_one      <= drv_item.st1;
                i_status_three    <= drv_item.st3;
                i_voltage_high    <= drv_item.vhi;
                i_current_high    <= drv_item.ihi;
                i_low_bits        <= drv_item.lsb;
                start             <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                              : $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predicts each accepted item and checks each result as it appears.
    always @(posedge i_clk) begin
        took_item <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy)
                reading_expected.push_back(convert_reading(
                    '{i_current_control, i_status_one, i_status_three,
                      i_voltage_high, i_current_high, i_low_bits},
                    charge_cal_now, disch_cal_now));
            if (o_result_valid) begin
                got = '{t_status'(o_status), o_battery_millivolts, o_battery_microamps};
                if (reading_expected.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = reading_expected.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.mv != want.mv)
                        report_mismatch($sformatf("millivolts %0d, expected %0d",
                                                  got.mv, want.mv));
                    if (got.ua != want.ua)
                        report_mismatch($sformatf("microamps %0d, expected %0d",
                                                  $signed(got.ua), $signed(want.ua)));
                end
            end
        end
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [CAL_W-1:0] cal_a;
        logic [CAL_W-1:0] cal_b;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_current_control = '0;
        i_status_one      = '0;
        i_status_three    = '0;
        i_voltage_high    = '0;
        i_current_high    = '0;
        i_low_bits        = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_CHARGE_CAL;
        i_cfg_data        = '0;
        charge_cal_now    = CAL_RESET;
        disch_cal_now     = CAL_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Flag precedence, every mode, and the sample extremes at reset calibration.
        meas_pending.push_back(mk(8'hFF, {2'b01, MODE_CHARGE, 3'b000}, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        meas_pending.push_back(mk(8'hFF, {2'b10, MODE_CHARGE, 3'b000}, 8'hF7, 8'hFF, 8'hFF, 8'hFF));
        meas_pending.push_back(mk(8'h10, {2'b11, MODE_BAD_7, 3'b111}, 8'hFF, 8'h80, 8'h80, 8'h00));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_CHARGE, 3'b000}, 8'h01, 8'hFF, 8'hFF, 8'hFF));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_CHARGE, 3'b000}, 8'h80, 8'hFF, 8'hFF, 8'hFF));
        meas_pending.push_back(mk(8'h00, {2'b00, MODE_BAD_6, 3'b000}, 8'h04, 8'hFF, 8'hFF, 8'hFF));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_CHARGE, 3'b111}, 8'h08, 8'hFF, 8'hFF, 8'hFF));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_BAD_5, 3'b000}, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_BAD_6, 3'b000}, 8'h08, 8'hFF, 8'hFF, 8'hFF));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_BAD_7, 3'b000}, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_IDLE, 3'b000}, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_IDLE, 3'b000}, 8'h00, 8'h00, 8'hFF, 8'hF0));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_CHARGE, 3'b000}, 8'h00, 8'h00, 8'hFF, 8'h0F));
        meas_pending.push_back(mk(8'h00, {2'b00, MODE_CHARGE, 3'b000}, 8'h00, 8'h55, 8'h11, 8'h04));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_CHARGE, 3'b000}, 8'h00, 8'h55, 8'h11, 8'h03));
        meas_pending.push_back(mk(8'h80, {2'b00, MODE_DROPOUT, 3'b000}, 8'h08, 8'hAA, 8'h7D, 8'h00));
        meas_pending.push_back(mk(8'h00, {2'b00, MODE_SUPPLEMENT, 3'b000}, 8'h00, 8'h12, 8'hFF, 8'h0C));
        meas_pending.push_back(mk(8'h00, {2'b00, MODE_SUPPLEMENT, 3'b000}, 8'h00, 8'h12, 8'h11, 8'h00));
        meas_pending.push_back(mk(8'hFF, {2'b00, MODE_DISCHARGE, 3'b000}, 8'h08, 8'hFF, 8'hFF, 8'h0F));
        meas_pending.push_back(mk(8'h00, {2'b00, MODE_DISCHARGE, 3'b000}, 8'h00, 8'h01, 8'h11, 8'h04));
        meas_pending.push_back(mk(8'h7F, {2'b00, MODE_DISCHARGE, 3'b000}, 8'h00, 8'h40, 8'h00, 8'h00));
        wait_drained();

        // Each pass rewrites both calibrations, covering zero, the smallest and the largest.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin cal_a = CAL_RESET; cal_b = CAL_RESET; end
                1: begin cal_a = 14'd11;    cal_b = 14'd11;    end
                2: begin cal_a = 14'd0;     cal_b = 14'd16383; end
                3: begin cal_a = 14'd16383; cal_b = 14'd0;     end
                4: begin cal_a = 14'd1;     cal_b = 14'd1;     end
                5: begin
                    cal_a = 14'($urandom_range(11, 14321));
                    cal_b = 14'($urandom_range(11, 14321));
                end
                default: begin
                    cal_a = 14'($urandom_range(0, 16383));
                    cal_b = 14'($urandom_range(0, 16383));
                end
            endcase
            write_cal(CFG_CHARGE_CAL, cal_a);
            write_cal(CFG_DISCHARGE_CAL, cal_b);
            for (int n = 0; n < ITEMS_PER_CAL; n++)
                meas_pending.push_back(random_reading());
            wait_drained();
        end

        repeat (LATENCY + 5) @(posedge i_clk);
        if (mismatches == 0 && reading_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
